@@ rtl/core/sspc_pkg.sv @@
// shared constants and types for the subarray sum prefix counter
// no dependencies; every other file of the block depends on this package

package sspc_pkg;

   localparam int MAX_LEN      = 1024;
   localparam int SAMPLE_WIDTH = 16;
   localparam int TARGET_W     = 26;
   localparam int COUNT_W      = 20;

   // fill level counts up to MAX_LEN inclusive
   localparam int FILL_W = $clog2(MAX_LEN + 1);
   // exact prefix sum over MAX_LEN samples
   localparam int SUM_W  = SAMPLE_WIDTH + $clog2(MAX_LEN) + 1;
   // prefix minus target, exact
   localparam int WANT_W = ((SUM_W > TARGET_W) ? SUM_W : TARGET_W) + 1;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // query item walking down the cell row
   typedef struct packed {
      logic                     valid;
      logic                     last;
      logic                     ovf;
      logic [FILL_W-1:0]        limit;   // cells below this index take part
      logic [FILL_W-1:0]        count;   // matches found so far
      logic signed [WANT_W-1:0] want;    // prefix value that makes a match
   } token_type;

   // store write broadcast to all cells
   typedef struct packed {
      logic                    en;
      logic [FILL_W-1:0]       idx;
      logic signed [SUM_W-1:0] data;
   } wr_type;

endpackage

@@ rtl/core/sspc_if.sv @@
// channel interfaces of the subarray sum prefix counter: sample, result, register write
// depends on sspc_pkg

interface sspc_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [sspc_pkg::SAMPLE_WIDTH-1:0] sample;
   logic                                   last;

   modport source (output valid, output sample, output last, input ready);
   modport sink   (input valid, input sample, input last, output ready);
endinterface

interface sspc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [sspc_pkg::COUNT_W-1:0]    run_count;
   logic                            overflow;

   modport source (output valid, output run_count, output overflow, input ready);
   modport sink   (input valid, input run_count, input overflow, output ready);
endinterface

interface sspc_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [sspc_pkg::TARGET_W-1:0]   target_sum;

   modport source (output valid, output target_sum, input ready);
   modport sink   (input valid, input target_sum, output ready);
endinterface

@@ rtl/core/sspc_head.sv @@
// front end: target register, running prefix sum, fill level, overflow flag
// issues store writes and query items into the cell row; depends on sspc_pkg, sspc_if

module sspc_head (
   input  logic               clock,
   input  logic               reset,
   sspc_req_if.sink           req,
   sspc_csr_if.sink           csr,
   input  logic               rsp_done,
   output sspc_pkg::wr_type    wr,
   output sspc_pkg::token_type tok_out
);
   import sspc_pkg::*;

   logic signed [TARGET_W-1:0] target_ff, target_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [FILL_W-1:0]          fill_ff, fill_in;
   logic                       ovf_ff, ovf_in;
   logic                       busy_ff, busy_in;
   logic                       tok_valid_ff, tok_valid_in;
   token_type                  tok_data_ff, tok_data_in;

   logic                       accept;
   logic                       room;
   logic signed [SUM_W-1:0]    sample_ext;
   logic signed [SUM_W-1:0]    sum_next;

   assign req.ready = !busy_ff;
   assign csr.ready = 1'b1;
   assign accept    = req.valid && !busy_ff;
   assign room      = (fill_ff < FILL_W'(MAX_LEN));

   assign sample_ext = SUM_W'(req.sample);
   assign sum_next   = sum_ff + sample_ext;

   always_comb begin
      target_in = target_ff;
      sum_in    = sum_ff;
      fill_in   = fill_ff;
      ovf_in    = ovf_ff;
      busy_in   = busy_ff;

      if (csr.valid) begin
         target_in = csr.target_sum;
      end

      if (accept) begin
         if (room) begin
            sum_in  = sum_next;
            fill_in = fill_ff + FILL_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
         if (req.last) begin
            sum_in  = '0;
            fill_in = '0;
            ovf_in  = 1'b0;
            busy_in = 1'b1;
         end
      end

      if (rsp_done) begin
         busy_in = 1'b0;
      end

      // dropped samples make no query unless they close the sequence
      tok_valid_in      = accept && (room || req.last);
      tok_data_in.valid = 1'b1;
      tok_data_in.last  = req.last;
      tok_data_in.ovf   = ovf_ff | !room;
      tok_data_in.limit = room ? (fill_ff + FILL_W'(1)) : '0;
      tok_data_in.count = '0;
      tok_data_in.want  = WANT_W'(sum_next) - WANT_W'(target_ff);

      wr.en   = accept && room;
      wr.idx  = fill_ff;
      wr.data = sum_ff;

      tok_out       = tok_data_ff;
      tok_out.valid = tok_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= '0;
         sum_ff       <= '0;
         fill_ff      <= '0;
         ovf_ff       <= 1'b0;
         busy_ff      <= 1'b0;
         tok_valid_ff <= 1'b0;
      end else begin
         target_ff    <= target_in;
         sum_ff       <= sum_in;
         fill_ff      <= fill_in;
         ovf_ff       <= ovf_in;
         busy_ff      <= busy_in;
         tok_valid_ff <= tok_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_data_ff <= tok_data_in;
   end

endmodule

@@ rtl/core/sspc_cell.sv @@
// one cell of the row: holds one stored prefix and checks each passing query item
// depends on sspc_pkg

module sspc_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [sspc_pkg::FILL_W-1:0] cell_idx,
   input  sspc_pkg::wr_type             wr,
   input  sspc_pkg::token_type          tok_in,
   output sspc_pkg::token_type          tok_out
);
   import sspc_pkg::*;

   logic signed [SUM_W-1:0] store_ff;
   logic                    valid_ff, valid_in;
   token_type               data_ff, data_in;
   logic                    hit;

   assign hit = tok_in.valid && (cell_idx < tok_in.limit)
                && ($signed(WANT_W'(store_ff)) == $signed(tok_in.want));

   always_comb begin
      valid_in      = tok_in.valid;
      data_in       = tok_in;
      data_in.count = tok_in.count + FILL_W'(hit);
      tok_out       = data_ff;
      tok_out.valid = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (wr.en && (wr.idx == cell_idx)) begin
         store_ff <= wr.data;
      end
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

@@ rtl/core/sspc_tail.sv @@
// end of the row: sums per-item match counts and holds the result register
// depends on sspc_pkg, sspc_if

module sspc_tail (
   input  logic               clock,
   input  logic               reset,
   input  sspc_pkg::token_type tok_in,
   sspc_rsp_if.source         rsp
);
   import sspc_pkg::*;

   logic [COUNT_W-1:0] acc_ff, acc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic [COUNT_W:0]   wide_sum;
   logic [COUNT_W-1:0] sat_sum;

   assign wide_sum = (COUNT_W+1)'(acc_ff) + (COUNT_W+1)'(tok_in.count);
   assign sat_sum  = wide_sum[COUNT_W] ? COUNT_MAX : wide_sum[COUNT_W-1:0];

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.run_count = count_ff;
   assign rsp.overflow  = ovf_ff;

   always_comb begin
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (tok_in.valid) begin
         if (tok_in.last) begin
            acc_in       = '0;
            rsp_valid_in = 1'b1;
            count_in     = sat_sum;
            ovf_in       = tok_in.ovf;
         end else begin
            acc_in = sat_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      ovf_ff   <= ovf_in;
   end

endmodule

@@ rtl/core/subarray_sum_prefix_count_top.sv @@
// result path: head register, the row of MAX_LEN cells (most of the delay), tail result register
// throughput: one item per cycle inside a sequence; after a last item no item is taken until
//   its result is delivered
// reset: synchronous, active high; clears prefix sum, fill level, flags, running count and the
//   target register (to zero); stored prefixes and the result count and overflow are not cleared
// depends on sspc_pkg, sspc_if, sspc_head, sspc_cell, sspc_tail

module subarray_sum_prefix_count_top (
   input  logic       clock,
   input  logic       reset,
   sspc_req_if.sink   req_chan,
   sspc_rsp_if.source rsp_chan,
   sspc_csr_if.sink   csr_chan
);
   import sspc_pkg::*;

   // query items between stages; chain[0] leaves the head, chain[MAX_LEN] reaches the tail
   token_type chain [0:MAX_LEN];
   wr_type    wr;
   logic      rsp_done;

   // result taken: the front end may open the next sequence
   assign rsp_done = rsp_chan.valid && rsp_chan.ready;

   // front end: each item that finds room records the old prefix in cell fill_level, then launches a
   // query for (new prefix - target) limited to cells below the new fill level
   sspc_head u_head (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .csr     (csr_chan),
      .rsp_done(rsp_done),
      .wr      (wr),
      .tok_out (chain[0])
   );

   // row of cells: a query moves one cell per cycle; a store write lands in its cell
   // before any query that may count it arrives there, and later writes sit above the
   // limit of every query already in flight
   for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
      sspc_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .cell_idx(FILL_W'(k)),
         .wr      (wr),
         .tok_in  (chain[k]),
         .tok_out (chain[k+1])
      );
   end

   // tail: saturating sum of per-item counts, result register on the last item
   sspc_tail u_tail (
      .clock (clock),
      .reset (reset),
      .tok_in(chain[MAX_LEN]),
      .rsp   (rsp_chan)
   );

   // no new item while a result is still waiting to be taken
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |-> !rsp_chan.valid)
      else $error("item accepted while result pending");

   // no query reaches the tail while the result register is occupied
   assert property (@(posedge clock) disable iff (reset)
      chain[MAX_LEN].valid |-> !rsp_chan.valid)
      else $error("query reached tail while result pending");

   // a closing query shows up as a result on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (chain[MAX_LEN].valid && chain[MAX_LEN].last) |=> rsp_chan.valid)
      else $error("closing query did not produce a result");

   // queries start with no matches counted
   assert property (@(posedge clock) disable iff (reset)
      chain[0].valid |-> (chain[0].count == '0))
      else $error("query launched with nonzero count");

endmodule
